>>> rtl/mss_pkg.sv
`timescale 1ns / 1ps

package mss_pkg;

  typedef logic [31:0] ms_t;
  typedef logic [1:0]  req_t;
  typedef logic [1:0]  kind_t;
  typedef logic [2:0]  tstate_t;
  typedef logic [1:0]  pstat_t;
  typedef logic [15:0] tmo_t;

  // event codes on req_type
  localparam req_t REQ_UPDATE = 2'd0;
  localparam req_t REQ_RESULT = 2'd1;
  localparam req_t REQ_CANCEL = 2'd2;
  localparam req_t REQ_START  = 2'd3;

  // command kinds
  localparam kind_t CMD_ENABLE = 2'd0;
  localparam kind_t CMD_ORIGIN = 2'd1;
  localparam kind_t CMD_PATH   = 2'd2;

  // path status codes
  localparam pstat_t PST_RUNNING = 2'd0;
  localparam pstat_t PST_DONE    = 2'd1;
  localparam pstat_t PST_FAILED  = 2'd2;
  localparam pstat_t PST_ABORTED = 2'd3;

  // register map, index = paddr[3:2]
  localparam int          ADDR_W       = 4;
  localparam logic [1:0]  REG_ENABLE   = 2'd0;
  localparam logic [1:0]  REG_SETUP    = 2'd1;
  localparam logic [1:0]  REG_SEGMENT  = 2'd2;
  localparam logic [1:0]  REG_REPEAT   = 2'd3;

  localparam tmo_t SETUP_TMO_RST   = 16'd5000;
  localparam tmo_t SEGMENT_TMO_RST = 16'd10000;
  localparam tmo_t REPEAT_DLY_RST  = 16'd500;

endpackage

>>> rtl/mss_if.sv
`timescale 1ns / 1ps

interface mss_in_if;
  logic               valid;
  logic               ready;
  mss_pkg::req_t      req_type;
  mss_pkg::ms_t       now_ms;
  logic               cmd_accepted;
  logic               motor_fault;
  logic               motor_ok;
  logic               motor_pending;
  logic               enable_asked;
  logic               enabled_flag;
  mss_pkg::ms_t       flag_stamp;
  mss_pkg::ms_t       pos_stamp;
  logic               zero_confirmed;
  mss_pkg::pstat_t    path_status;

  modport source (output valid, req_type, now_ms, cmd_accepted, motor_fault, motor_ok,
                  motor_pending, enable_asked, enabled_flag, flag_stamp, pos_stamp,
                  zero_confirmed, path_status, input ready);
  modport sink (input valid, req_type, now_ms, cmd_accepted, motor_fault, motor_ok,
                motor_pending, enable_asked, enabled_flag, flag_stamp, pos_stamp,
                zero_confirmed, path_status, output ready);
endinterface

interface mss_out_if;
  logic               valid;
  logic               ready;
  logic               cmd_valid;
  mss_pkg::kind_t     cmd_kind;
  mss_pkg::tstate_t   test_state;
  mss_pkg::ms_t       rounds_done;

  modport source (output valid, cmd_valid, cmd_kind, test_state, rounds_done, input ready);
  modport sink (input valid, cmd_valid, cmd_kind, test_state, rounds_done, output ready);
endinterface

>>> rtl/motor_selftest_sequencer.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Word
// in_ch     in   valid/ready          event: type, now_ms, motor status bits, timestamps
// out_ch    out  valid/ready          cmd_valid, cmd_kind, test_state, rounds_done
// cfg (APB) in   psel/penable/pready  4 registers (1/16/16/16 bits) at 0x0, 0x4, 0x8, 0xC
//
// One word in per cycle unless a stalled out_ch backs up the input register, one result
// word per input word (input register, then step logic into the result register and sequencer state).
// Rate is set by the input/result register pair; the step logic is one 32-bit
// subtract and compare per check.
// rst_n is synchronous, active low: state idles in disabled, registers take defaults.
// A stalled out_ch holds the result; the input register still takes a word if empty.

module motor_selftest_sequencer (
  input  logic                     clk,
  input  logic                     rst_n,
  mss_in_if.sink                   in_ch,
  mss_out_if.source                out_ch,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [mss_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  typedef enum logic [2:0] {
    ST_DISABLED = 3'd0,
    ST_WAIT     = 3'd1,
    ST_ENABLE   = 3'd2,
    ST_ZERO     = 3'd3,
    ST_PATH     = 3'd4,
    ST_PAUSE    = 3'd5,
    ST_STOPPED  = 3'd6,
    ST_FAILED   = 3'd7
  } step_t;

  // ---------------- configuration registers ----------------
  logic               st_en_r;
  mss_pkg::tmo_t      setup_tmo_r;
  mss_pkg::tmo_t      seg_tmo_r;
  mss_pkg::tmo_t      rpt_dly_r;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_en_r     <= 1'b0;
      setup_tmo_r <= mss_pkg::SETUP_TMO_RST;
      seg_tmo_r   <= mss_pkg::SEGMENT_TMO_RST;
      rpt_dly_r   <= mss_pkg::REPEAT_DLY_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        mss_pkg::REG_ENABLE:  st_en_r     <= pwdata[0];
        mss_pkg::REG_SETUP:   setup_tmo_r <= pwdata[15:0];
        mss_pkg::REG_SEGMENT: seg_tmo_r   <= pwdata[15:0];
        mss_pkg::REG_REPEAT:  rpt_dly_r   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mss_pkg::REG_ENABLE:  prdata = {31'd0, st_en_r};
      mss_pkg::REG_SETUP:   prdata = {16'd0, setup_tmo_r};
      mss_pkg::REG_SEGMENT: prdata = {16'd0, seg_tmo_r};
      mss_pkg::REG_REPEAT:  prdata = {16'd0, rpt_dly_r};
      default:              prdata = 32'd0;
    endcase
  end

  // ---------------- input register ----------------
  logic               s1_vld_r;
  mss_pkg::req_t      req_r;
  mss_pkg::ms_t       now_r;
  logic               acc_bit_r;
  logic               fault_r;
  logic               healthy_r;
  logic               pending_r;
  logic               en_req_r;
  logic               en_flag_r;
  mss_pkg::ms_t       flag_stamp_r;
  mss_pkg::ms_t       pos_stamp_r;
  logic               zero_ok_r;
  mss_pkg::pstat_t    pstat_r;

  logic               out_vld_r;
  logic               advance;   // result register free this cycle
  logic               s1_fire;   // word in input register is processed
  logic               in_fire;

  assign advance     = !out_vld_r || out_ch.ready;
  assign s1_fire     = s1_vld_r && advance;
  assign in_ch.ready = !s1_vld_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_vld_r <= in_ch.valid;
    end
    if (in_fire) begin
      req_r        <= in_ch.req_type;
      now_r        <= in_ch.now_ms;
      acc_bit_r    <= in_ch.cmd_accepted;
      fault_r      <= in_ch.motor_fault;
      healthy_r    <= in_ch.motor_ok;
      pending_r    <= in_ch.motor_pending;
      en_req_r     <= in_ch.enable_asked;
      en_flag_r    <= in_ch.enabled_flag;
      flag_stamp_r <= in_ch.flag_stamp;
      pos_stamp_r  <= in_ch.pos_stamp;
      zero_ok_r    <= in_ch.zero_confirmed;
      pstat_r      <= in_ch.path_status;
    end
  end

  // ---------------- sequencer state ----------------
  step_t              step_r, step_nxt;
  mss_pkg::ms_t       since_r, since_nxt;
  logic               disp_r, disp_nxt;
  mss_pkg::ms_t       acc_at_r, acc_at_nxt;
  mss_pkg::ms_t       rounds_r, rounds_nxt;
  logic               cmd_v_r, cmd_v_nxt;
  mss_pkg::kind_t     kind_r, kind_nxt;

  // elapsed time in this step, wrapping
  mss_pkg::ms_t       elapsed;
  logic [17:0]        limit;     // 2*segment + setup in path, else setup
  logic               timed_out;
  logic               pause_done;
  logic               terminal;
  mss_pkg::ms_t       fl_diff;
  mss_pkg::ms_t       pos_diff;
  logic               fl_fresh;  // flags read back strictly after command accept
  logic               pos_fresh;

  assign elapsed    = now_r - since_r;
  assign limit      = (step_r == ST_PATH) ? ({1'b0, seg_tmo_r, 1'b0} + {2'd0, setup_tmo_r})
                                          : {2'd0, setup_tmo_r};
  assign timed_out  = elapsed >= {14'd0, limit};
  assign pause_done = elapsed >= {16'd0, rpt_dly_r};
  assign terminal   = (step_r == ST_DISABLED) || (step_r == ST_STOPPED) ||
                      (step_r == ST_FAILED);
  assign fl_diff    = flag_stamp_r - acc_at_r;
  assign pos_diff   = pos_stamp_r - acc_at_r;
  assign fl_fresh   = (fl_diff != 32'd0) && !fl_diff[31];
  assign pos_fresh  = (pos_diff != 32'd0) && !pos_diff[31];

  always_comb begin
    step_nxt   = step_r;
    since_nxt  = since_r;
    disp_nxt   = disp_r;
    acc_at_nxt = acc_at_r;
    rounds_nxt = rounds_r;
    cmd_v_nxt  = 1'b0;
    kind_nxt   = mss_pkg::CMD_ENABLE;
    case (req_r)
      mss_pkg::REQ_START: begin
        step_nxt   = st_en_r ? ST_WAIT : ST_DISABLED;
        since_nxt  = now_r;
        disp_nxt   = 1'b0;
        acc_at_nxt = 32'd0;
        rounds_nxt = 32'd0;
      end
      mss_pkg::REQ_CANCEL: begin
        if (step_r != ST_DISABLED && step_r != ST_FAILED) begin
          step_nxt = ST_STOPPED;
        end
      end
      mss_pkg::REQ_RESULT: begin
        if (!terminal) begin
          if (!acc_bit_r) begin
            step_nxt = ST_FAILED;
          end else begin
            disp_nxt   = 1'b1;
            acc_at_nxt = now_r;
            since_nxt  = now_r;
          end
        end
      end
      default: begin
        // update: fault, timeout, health, then the step itself
        if (!terminal) begin
          if (fault_r || timed_out) begin
            step_nxt = ST_FAILED;
          end else if (step_r != ST_WAIT && step_r != ST_ZERO && !healthy_r) begin
            step_nxt = ST_FAILED;
          end else begin
            case (step_r)
              ST_WAIT: begin
                if (healthy_r) begin
                  step_nxt  = ST_ENABLE;
                  since_nxt = now_r;
                  disp_nxt  = 1'b0;
                end
              end
              ST_ENABLE: begin
                if (!disp_r) begin
                  cmd_v_nxt = 1'b1;
                  kind_nxt  = mss_pkg::CMD_ENABLE;
                end else if (!pending_r && en_req_r && en_flag_r && fl_fresh) begin
                  step_nxt  = ST_ZERO;
                  since_nxt = now_r;
                  disp_nxt  = 1'b0;
                end
              end
              ST_ZERO: begin
                if (!disp_r) begin
                  cmd_v_nxt = 1'b1;
                  kind_nxt  = mss_pkg::CMD_ORIGIN;
                end else if (healthy_r && !pending_r && zero_ok_r && en_req_r &&
                             en_flag_r && pos_fresh && fl_fresh) begin
                  step_nxt  = ST_PATH;
                  since_nxt = now_r;
                  disp_nxt  = 1'b0;
                end
              end
              ST_PATH: begin
                if (!disp_r) begin
                  cmd_v_nxt = 1'b1;
                  kind_nxt  = mss_pkg::CMD_PATH;
                end else if (pstat_r == mss_pkg::PST_FAILED ||
                             pstat_r == mss_pkg::PST_ABORTED) begin
                  step_nxt = ST_FAILED;
                end else if (pstat_r == mss_pkg::PST_DONE) begin
                  rounds_nxt = rounds_r + 32'd1;
                  step_nxt   = ST_PAUSE;
                  since_nxt  = now_r;
                  disp_nxt   = 1'b0;
                end
              end
              ST_PAUSE: begin
                if (pause_done) begin
                  step_nxt  = ST_PATH;
                  since_nxt = now_r;
                  disp_nxt  = 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
      end
    endcase
  end

  // state and result register together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= ST_DISABLED;
      since_r   <= 32'd0;
      disp_r    <= 1'b0;
      acc_at_r  <= 32'd0;
      rounds_r  <= 32'd0;
      out_vld_r <= 1'b0;
      cmd_v_r   <= 1'b0;
      kind_r    <= mss_pkg::CMD_ENABLE;
    end else if (s1_fire) begin
      step_r    <= step_nxt;
      since_r   <= since_nxt;
      disp_r    <= disp_nxt;
      acc_at_r  <= acc_at_nxt;
      rounds_r  <= rounds_nxt;
      out_vld_r <= 1'b1;
      cmd_v_r   <= cmd_v_nxt;
      kind_r    <= kind_nxt;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.cmd_valid   = cmd_v_r;
  assign out_ch.cmd_kind    = kind_r;
  assign out_ch.test_state  = step_r;
  assign out_ch.rounds_done = rounds_r;

  // ---------------- assertions ----------------
  a_cmd_only_active: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_v_r |-> (step_r == ST_ENABLE || step_r == ST_ZERO || step_r == ST_PATH))
    else $error("command requested outside enable/zero/path");

  a_kind_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd_v_r |-> kind_r == mss_pkg::CMD_ENABLE)
    else $error("cmd_kind nonzero without cmd_valid");

  a_rounds_only_on_step: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(rounds_r) && $stable(step_r))
    else $error("sequencer state moved without a processed word");

  a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && step_r == ST_FAILED && req_r != mss_pkg::REQ_START) |=> step_r == ST_FAILED)
    else $error("failed state left without start");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_vld_r && out_vld_r && !out_ch.ready))
    else $error("input stalled with room in the pipeline");

endmodule

>>> tb/motor_selftest_sequencer_tb.sv
`timescale 1ns / 1ps

module motor_selftest_sequencer_tb;

  // Sequencer states as seen on test_state
  typedef enum logic [2:0] {
    STEP_OFF     = 3'd0,
    STEP_WAIT    = 3'd1,
    STEP_ENABLE  = 3'd2,
    STEP_ZERO    = 3'd3,
    STEP_PATH    = 3'd4,
    STEP_PAUSE   = 3'd5,
    STEP_STOPPED = 3'd6,
    STEP_FAILED  = 3'd7
  } step_t;

  // One input word
  typedef struct packed {
    mss_pkg::req_t   req_type;
    mss_pkg::ms_t    now_ms;
    logic            cmd_accepted;
    logic            motor_fault;
    logic            motor_ok;
    logic            motor_pending;
    logic            enable_asked;
    logic            enabled_flag;
    mss_pkg::ms_t    flag_stamp;
    mss_pkg::ms_t    pos_stamp;
    logic            zero_confirmed;
    mss_pkg::pstat_t path_status;
  } evt_t;

  // One result word
  typedef struct packed {
    logic             cmd_valid;
    mss_pkg::kind_t   cmd_kind;
    mss_pkg::tstate_t test_state;
    mss_pkg::ms_t     rounds_done;
  } res_t;

  localparam int CYCLE_LIMIT  = 300000;  // generous watchdog
  localparam int SETTLE_CYCLES = 20;     // pipeline is 2 deep
  localparam int PRINT_CAP    = 50;

  // Scoreboard: shadow copy of the sequencer plus the queue of words it owes us.
  class scoreboard_t;
    logic          run_enabled;
    mss_pkg::tmo_t setup_tmo, segment_tmo, repeat_dly;
    step_t         step;
    mss_pkg::ms_t  since, accepted_at, rounds;
    logic          dispatched;
    res_t          due_q[$];
    int            errors;
    int            words_seen;

    function new();
      errors     = 0;
      words_seen = 0;
      run_enabled = 1'b0;
      setup_tmo   = mss_pkg::SETUP_TMO_RST;
      segment_tmo = mss_pkg::SEGMENT_TMO_RST;
      repeat_dly  = mss_pkg::REPEAT_DLY_RST;
      step        = STEP_OFF;
      since       = '0;
      accepted_at = '0;
      rounds      = '0;
      dispatched  = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        mss_pkg::REG_ENABLE:  run_enabled = val[0];
        mss_pkg::REG_SETUP:   setup_tmo   = val[15:0];
        mss_pkg::REG_SEGMENT: segment_tmo = val[15:0];
        mss_pkg::REG_REPEAT:  repeat_dly  = val[15:0];
        default: ;
      endcase
    endfunction

    function bit is_terminal();
      return step == STEP_OFF || step == STEP_STOPPED || step == STEP_FAILED;
    endfunction

    // path gets two segments plus setup, everything else just setup
    function mss_pkg::ms_t step_limit();
      if (step == STEP_PATH)
        return {15'd0, segment_tmo, 1'b0} + {16'd0, setup_tmo};
      return {16'd0, setup_tmo};
    endfunction

    // signed 32-bit "a is strictly after b"
    function bit later(mss_pkg::ms_t a, mss_pkg::ms_t b);
      mss_pkg::ms_t d;
      d = a - b;
      return d != '0 && !d[31];
    endfunction

    function void enter(step_t s, mss_pkg::ms_t now);
      step       = s;
      since      = now;
      dispatched = 1'b0;
    endfunction

    function res_t apply_update(evt_t e);
      res_t         r;
      mss_pkg::ms_t elapsed;
      r = '0;
      elapsed = e.now_ms - since;
      if (is_terminal()) return r;
      // fault, then timeout, then health
      if (e.motor_fault) begin
        step = STEP_FAILED;
        return r;
      end
      if (elapsed >= step_limit()) begin
        step = STEP_FAILED;
        return r;
      end
      if (step != STEP_WAIT && step != STEP_ZERO && !e.motor_ok) begin
        step = STEP_FAILED;
        return r;
      end
      case (step)
        STEP_WAIT: if (e.motor_ok) enter(STEP_ENABLE, e.now_ms);
        STEP_ENABLE: begin
          if (!dispatched) begin
            r.cmd_valid = 1'b1;
            r.cmd_kind  = mss_pkg::CMD_ENABLE;
          end else if (!e.motor_pending && e.enable_asked && e.enabled_flag &&
                       later(e.flag_stamp, accepted_at)) begin
            enter(STEP_ZERO, e.now_ms);
          end
        end
        STEP_ZERO: begin
          if (!dispatched) begin
            r.cmd_valid = 1'b1;
            r.cmd_kind  = mss_pkg::CMD_ORIGIN;
          end else if (e.motor_ok && !e.motor_pending && e.zero_confirmed &&
                       e.enable_asked && e.enabled_flag &&
                       later(e.pos_stamp, accepted_at) &&
                       later(e.flag_stamp, accepted_at)) begin
            enter(STEP_PATH, e.now_ms);
          end
        end
        STEP_PATH: begin
          if (!dispatched) begin
            r.cmd_valid = 1'b1;
            r.cmd_kind  = mss_pkg::CMD_PATH;
          end else if (e.path_status == mss_pkg::PST_FAILED ||
                       e.path_status == mss_pkg::PST_ABORTED) begin
            step = STEP_FAILED;
          end else if (e.path_status == mss_pkg::PST_DONE) begin
            rounds = rounds + 32'd1;
            enter(STEP_PAUSE, e.now_ms);
          end
        end
        STEP_PAUSE: if (elapsed >= {16'd0, repeat_dly}) enter(STEP_PATH, e.now_ms);
        default: ;
      endcase
      return r;
    endfunction

    // advance the shadow sequencer by one accepted word, queue what it owes
    function void step_sequence(evt_t e);
      res_t r;
      r = '0;
      case (e.req_type)
        mss_pkg::REQ_START: begin
          accepted_at = '0;
          rounds      = '0;
          enter(run_enabled ? STEP_WAIT : STEP_OFF, e.now_ms);
        end
        mss_pkg::REQ_CANCEL: if (step != STEP_OFF && step != STEP_FAILED) step = STEP_STOPPED;
        mss_pkg::REQ_RESULT: begin
          if (!is_terminal()) begin
            if (!e.cmd_accepted) begin
              step = STEP_FAILED;
            end else begin
              dispatched  = 1'b1;
              accepted_at = e.now_ms;
              since       = e.now_ms;
            end
          end
        end
        default: r = apply_update(e);
      endcase
      r.test_state  = step;
      r.rounds_done = rounds;
      due_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_CAP) $display("MISMATCH word %0d: %s", words_seen, msg);
    endtask

    task compare_word(res_t got);
      res_t want;
      words_seen++;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected word state=%0d rounds=%0d", got.test_state,
                         got.rounds_done));
        return;
      end
      want = due_q.pop_front();
      if (got.cmd_valid !== want.cmd_valid)
        report($sformatf("cmd_valid %0b, want %0b", got.cmd_valid, want.cmd_valid));
      if (got.cmd_kind !== want.cmd_kind)
        report($sformatf("cmd_kind %0d, want %0d", got.cmd_kind, want.cmd_kind));
      if (got.test_state !== want.test_state)
        report($sformatf("test_state %0d, want %0d", got.test_state, want.test_state));
      if (got.rounds_done !== want.rounds_done)
        report($sformatf("rounds_done %0d, want %0d", got.rounds_done, want.rounds_done));
    endtask
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [mss_pkg::ADDR_W-1:0] paddr;
  logic [31:0]                pwdata;
  logic [31:0]                prdata;
  logic                       pready;

  mss_in_if  in_ch ();
  mss_out_if out_ch ();

  motor_selftest_sequencer DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  scoreboard_t sb = new();

  int unsigned burst_left = 0;
  int unsigned rx_cycle   = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side. Ready follows its own pattern, rotating between always-ready,
  // coin flip, short dips and long stalls.
  // ---------------------------------------------------------------------------
  function automatic logic rx_ready(int unsigned c);
    case ((c / 157) % 4)
      0: return 1'b1;
      1: return ($urandom_range(0, 1) != 0);
      2: return (c % 5) != 0;
      default: return (c % 29) >= 20;
    endcase
  endfunction

  always @(posedge clk) begin : result_side
    res_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.cmd_valid   = out_ch.cmd_valid;
      got.cmd_kind    = out_ch.cmd_kind;
      got.test_state  = out_ch.test_state;
      got.rounds_done = out_ch.rounds_done;
      sb.compare_word(got);
    end
    out_ch.ready <= rx_ready(rx_cycle);
    rx_cycle++;
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Sender runs in bursts; between bursts valid drops for a random while.
  // Long bursts give stretches with no idling at all.
  task automatic drive_event(evt_t e);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 12);
    end
    in_ch.valid          <= 1'b1;
    in_ch.req_type       <= e.req_type;
    in_ch.now_ms         <= e.now_ms;
    in_ch.cmd_accepted   <= e.cmd_accepted;
    in_ch.motor_fault    <= e.motor_fault;
    in_ch.motor_ok       <= e.motor_ok;
    in_ch.motor_pending  <= e.motor_pending;
    in_ch.enable_asked   <= e.enable_asked;
    in_ch.enabled_flag   <= e.enabled_flag;
    in_ch.flag_stamp     <= e.flag_stamp;
    in_ch.pos_stamp      <= e.pos_stamp;
    in_ch.zero_confirmed <= e.zero_confirmed;
    in_ch.path_status    <= e.path_status;
    do @(posedge clk); while (!in_ch.ready);
    sb.step_sequence(e);
    burst_left--;
  endtask

  // Hold the sender off until every owed word has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.due_q.size() != 0) @(posedge clk);
  endtask

  // APB write: setup, access, then back to idle so back-to-back writes
  // never stack two assignments on psel in one step.
  task automatic apb_write(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // Every word yields a result, so once drained the block is idle.
  task automatic set_config(logic en, mss_pkg::tmo_t setup, mss_pkg::tmo_t seg,
                            mss_pkg::tmo_t rep);
    wait_drained();
    apb_write(mss_pkg::REG_ENABLE, {31'd0, en});
    apb_write(mss_pkg::REG_SETUP, {16'd0, setup});
    apb_write(mss_pkg::REG_SEGMENT, {16'd0, seg});
    apb_write(mss_pkg::REG_REPEAT, {16'd0, rep});
  endtask

  // Healthy word that meets the advance conditions of wait, enable and zero;
  // path status is running; feedback stamps one ms after the accepted command.
  function automatic evt_t good_event(mss_pkg::req_t req, int unsigned dt);
    evt_t e;
    e.req_type       = req;
    e.now_ms         = sb.since + dt;
    e.cmd_accepted   = 1'b1;
    e.motor_fault    = 1'b0;
    e.motor_ok       = 1'b1;
    e.motor_pending  = 1'b0;
    e.enable_asked   = 1'b1;
    e.enabled_flag   = 1'b1;
    e.flag_stamp     = sb.accepted_at + 32'd1;
    e.pos_stamp      = sb.accepted_at + 32'd1;
    e.zero_confirmed = 1'b1;
    e.path_status    = mss_pkg::PST_RUNNING;
    return e;
  endfunction

  function automatic evt_t random_event();
    evt_t e;
    e.req_type       = mss_pkg::req_t'($urandom_range(0, 3));
    e.now_ms         = $urandom();
    e.cmd_accepted   = ($urandom_range(0, 1) != 0);
    e.motor_fault    = ($urandom_range(0, 1) != 0);
    e.motor_ok       = ($urandom_range(0, 1) != 0);
    e.motor_pending  = ($urandom_range(0, 1) != 0);
    e.enable_asked   = ($urandom_range(0, 1) != 0);
    e.enabled_flag   = ($urandom_range(0, 1) != 0);
    e.flag_stamp     = $urandom();
    e.pos_stamp      = $urandom();
    e.zero_confirmed = ($urandom_range(0, 1) != 0);
    e.path_status    = mss_pkg::pstat_t'($urandom_range(0, 3));
    return e;
  endfunction

  // Mostly fresh feedback; sometimes equal, slightly older, or half a wrap off
  // (tests the signed compare).
  function automatic mss_pkg::ms_t stamp_near(mss_pkg::ms_t base);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return base + $urandom_range(1, 30);
    if (roll < 88) return base;
    if (roll < 94) return base - $urandom_range(1, 30);
    return base + 32'h8000_0000 - $urandom_range(0, 1);
  endfunction

  // Random word steered by the shadow state: mostly what a healthy motor
  // would report next, with a sprinkling of cancels, faults, timeouts,
  // unhealthy status, restarts and pure noise.
  function automatic evt_t next_event();
    evt_t        e;
    int unsigned lim, cap, dt, roll, rep;
    lim  = sb.step_limit();
    cap  = (lim - 1 < 40) ? lim - 1 : 40;
    dt   = $urandom_range(0, cap);
    roll = $urandom_range(0, 99);
    e    = good_event(mss_pkg::REQ_UPDATE, dt);
    if (sb.is_terminal()) begin
      if (roll < 85) begin
        e.req_type = mss_pkg::REQ_START;
        e.now_ms   = $urandom();
      end else begin
        e = random_event();
      end
      return e;
    end
    if (roll < 3) begin
      e.req_type = mss_pkg::REQ_CANCEL;
    end else if (roll < 7) begin
      e = random_event();
    end else if (roll < 9) begin
      e.motor_fault = 1'b1;
    end else if (roll < 11) begin
      e.now_ms = sb.since + lim + $urandom_range(0, 2);   // at or past the limit
    end else if (roll < 13) begin
      e.motor_ok = 1'b0;
    end else if (roll < 14) begin
      e.req_type = mss_pkg::REQ_START;
      e.now_ms   = $urandom();
    end else begin
      case (sb.step)
        STEP_WAIT: e.motor_ok = ($urandom_range(0, 3) != 0);
        STEP_ENABLE, STEP_ZERO, STEP_PATH: begin
          if (!sb.dispatched) begin
            // command asked for: dispatcher answers about half the time
            if ($urandom_range(0, 99) < 55) begin
              e.req_type     = mss_pkg::REQ_RESULT;
              e.cmd_accepted = ($urandom_range(0, 29) != 0);
            end
          end else begin
            e.motor_pending  = ($urandom_range(0, 9) == 0);
            e.enable_asked   = ($urandom_range(0, 9) != 0);
            e.enabled_flag   = ($urandom_range(0, 9) != 0);
            e.zero_confirmed = ($urandom_range(0, 9) != 0);
            e.flag_stamp     = stamp_near(sb.accepted_at);
            e.pos_stamp      = stamp_near(sb.accepted_at);
            roll = $urandom_range(0, 39);
            e.path_status = (roll < 24) ? mss_pkg::PST_RUNNING :
                            (roll < 38) ? mss_pkg::PST_DONE :
                            (roll < 39) ? mss_pkg::PST_FAILED : mss_pkg::PST_ABORTED;
          end
        end
        STEP_PAUSE: begin
          // land around the end of the repeat delay when it fits in setup
          rep = {16'd0, sb.repeat_dly};
          if (rep < lim) begin
            if ($urandom_range(0, 3) == 0) dt = $urandom_range(0, rep);
            else dt = $urandom_range(rep, (rep + 20 < lim - 1) ? rep + 20 : lim - 1);
            e.now_ms = sb.since + dt;
          end
        end
        default: ;
      endcase
    end
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    evt_t          e;
    int unsigned   counted, quota;
    mss_pkg::tmo_t stp;

    rst_n                = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_ch.valid          = 1'b0;
    in_ch.req_type       = mss_pkg::REQ_UPDATE;
    in_ch.now_ms         = '0;
    in_ch.cmd_accepted   = 1'b0;
    in_ch.motor_fault    = 1'b0;
    in_ch.motor_ok       = 1'b0;
    in_ch.motor_pending  = 1'b0;
    in_ch.enable_asked   = 1'b0;
    in_ch.enabled_flag   = 1'b0;
    in_ch.flag_stamp     = '0;
    in_ch.pos_stamp      = '0;
    in_ch.zero_confirmed = 1'b0;
    in_ch.path_status    = mss_pkg::PST_RUNNING;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Out of reset the test is off: start parks in disabled, updates do nothing.
    drive_event(good_event(mss_pkg::REQ_START, 0));
    drive_event(good_event(mss_pkg::REQ_UPDATE, 1));

    set_config(1'b1, mss_pkg::SETUP_TMO_RST, mss_pkg::SEGMENT_TMO_RST,
               mss_pkg::REPEAT_DLY_RST);

    // Full walk, timestamps wrapping through zero on the way.
    e = good_event(mss_pkg::REQ_START, 0);
    e.now_ms = 32'hFFFF_FFF0;
    drive_event(e);                                       // wait
    e = good_event(mss_pkg::REQ_UPDATE, 5);
    e.motor_ok = 1'b0;
    drive_event(e);                                       // wait tolerates unhealthy
    drive_event(good_event(mss_pkg::REQ_UPDATE, 20));     // -> enable
    drive_event(good_event(mss_pkg::REQ_UPDATE, 1));      // asks for enable
    drive_event(good_event(mss_pkg::REQ_RESULT, 2));
    e = good_event(mss_pkg::REQ_UPDATE, 3);
    e.flag_stamp = sb.accepted_at;
    drive_event(e);                                       // readback not newer: hold
    drive_event(good_event(mss_pkg::REQ_UPDATE, 4));      // -> zero
    drive_event(good_event(mss_pkg::REQ_UPDATE, 1));      // asks for origin
    drive_event(good_event(mss_pkg::REQ_RESULT, 1));
    e = good_event(mss_pkg::REQ_UPDATE, 2);
    e.motor_ok = 1'b0;
    drive_event(e);                                       // zero holds on unhealthy
    drive_event(good_event(mss_pkg::REQ_UPDATE, 3));      // -> path
    drive_event(good_event(mss_pkg::REQ_UPDATE, 0));      // asks for path
    drive_event(good_event(mss_pkg::REQ_RESULT, 7));
    e = good_event(mss_pkg::REQ_UPDATE, 9);
    e.path_status = mss_pkg::PST_DONE;
    drive_event(e);                                       // -> pause, one round
    drive_event(good_event(mss_pkg::REQ_UPDATE,
                           {16'd0, mss_pkg::REPEAT_DLY_RST} - 32'd1));  // one ms short
    drive_event(good_event(mss_pkg::REQ_UPDATE,
                           {16'd0, mss_pkg::REPEAT_DLY_RST}));          // -> path again
    drive_event(good_event(mss_pkg::REQ_UPDATE, 1));      // asks for path
    e = good_event(mss_pkg::REQ_RESULT, 1);
    e.cmd_accepted = 1'b0;
    drive_event(e);                                       // rejected -> failed
    drive_event(good_event(mss_pkg::REQ_CANCEL, 0));      // failed stays failed
    drive_event(good_event(mss_pkg::REQ_START, 0));
    drive_event(good_event(mss_pkg::REQ_CANCEL, 0));      // -> stopped
    drive_event(good_event(mss_pkg::REQ_START, 0));
    drive_event(good_event(mss_pkg::REQ_UPDATE,
                           {16'd0, mss_pkg::SETUP_TMO_RST}));  // exactly at the limit
    drive_event(good_event(mss_pkg::REQ_START, 0));
    e = good_event(mss_pkg::REQ_UPDATE, 1);
    e.motor_fault = 1'b1;
    drive_event(e);                                       // fault -> failed

    // Random phases: low extremes, high extremes, test off, then random settings.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_config(1'b1, 16'd1, 16'd1, 16'd0);
        1: set_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        2: set_config(1'b0, mss_pkg::tmo_t'($urandom_range(20, 65535)),
                      mss_pkg::tmo_t'($urandom_range(1, 65535)),
                      mss_pkg::tmo_t'($urandom_range(0, 65535)));
        default: begin
          stp = mss_pkg::tmo_t'($urandom_range(20, 65535));
          set_config(1'b1, stp, mss_pkg::tmo_t'($urandom_range(1, 65535)),
                     ($urandom_range(0, 3) == 0) ?
                       mss_pkg::tmo_t'($urandom_range(0, 65535)) :
                       mss_pkg::tmo_t'($urandom_range(0, {16'd0, stp} - 32'd1)));
        end
      endcase
      quota   = (ph == 2) ? 30 : 170;
      counted = 0;
      while (counted < quota) begin
        e = next_event();
        // words the block just drops don't count toward the phase
        if (!sb.is_terminal() || e.req_type == mss_pkg::REQ_START) counted++;
        drive_event(e);
        if ($urandom_range(0, 249) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.due_q.size() != 0)
      sb.report($sformatf("%0d words never arrived", sb.due_q.size()));

    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/mss_pkg.sv
rtl/mss_if.sv
rtl/motor_selftest_sequencer.sv
tb/motor_selftest_sequencer_tb.sv
